// File: design/assert_macros.svh
// assertion macros used by the top level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

`define ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg)

`define ASSERT_NEXT(lbl, clk, rst, pre, post, msg)

`endif

`endif

// File: design/srarq_pkg.sv
// types, constants and helpers of the selective repeat arq controller
package srarq_pkg;

  localparam int WINDOW       = 16;
  localparam int SEQ_COUNT    = 32;
  localparam int PACKET_BYTES = 256;

  localparam int SEQ_W  = $clog2(SEQ_COUNT);
  localparam int SLOT_W = $clog2(WINDOW);
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int LEN_W  = 9;
  localparam int REQ_W  = 3;
  localparam int KIND_W = 2;
  localparam int ACT_W  = 3;

  localparam int IN_TDATA_W  = 24;
  localparam int IN_TUSER_W  = REQ_W + KIND_W;
  localparam int OUT_TDATA_W = 24;
  localparam int OUT_TUSER_W = ACT_W;

  localparam int MIN_FRAME_LEN = 5;
  localparam int HEADER_BYTES  = 7;

  localparam logic [REQ_W-1:0] REQ_NET     = 3'd0;
  localparam logic [REQ_W-1:0] REQ_PHYS    = 3'd1;
  localparam logic [REQ_W-1:0] REQ_FRAME   = 3'd2;
  localparam logic [REQ_W-1:0] REQ_ACK_TO  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_DATA_TO = 3'd4;

  localparam logic [KIND_W-1:0] KIND_DATA  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ACK   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_NAK   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_OTHER = 2'd3;

  localparam logic [ACT_W-1:0] ACT_SEND      = 3'd0;
  localparam logic [ACT_W-1:0] ACT_ACK       = 3'd1;
  localparam logic [ACT_W-1:0] ACT_NAK       = 3'd2;
  localparam logic [ACT_W-1:0] ACT_ACK_TIMER = 3'd3;
  localparam logic [ACT_W-1:0] ACT_DELIVER   = 3'd4;
  localparam logic [ACT_W-1:0] ACT_STOP      = 3'd5;
  localparam logic [ACT_W-1:0] ACT_STATUS    = 3'd6;

  localparam int EMIT_KINDS = 9;

  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [LEN_W-1:0]  frame_len;
    logic              crc_ok;
    logic [KIND_W-1:0] rx_kind;
    logic [SEQ_W-1:0]  rx_seq;
    logic [SEQ_W-1:0]  rx_ack;
    logic [SLOT_W-1:0] timer_slot;
  } in_t;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [SEQ_W-1:0]  seq_out;
    logic [SEQ_W-1:0]  ack_out;
    logic [SLOT_W-1:0] slot;
    logic [LEN_W-1:0]  deliver_len;
    logic              net_enable;
    logic              last;
  } item_t;

  typedef struct packed {
    logic load;
    logic phys_set;
    logic mark;
    logic send_new;
    logic send_timeout;
    logic send_ack;
    logic send_nak;
    logic ack_tmr;
    logic deliver;
    logic send_resend;
    logic release_slot;
    logic status;
  } cmd_t;

  typedef struct packed {
    logic              emit_ok;
    logic [REQ_W-1:0]  req;
    logic [KIND_W-1:0] kind;
    logic              bad_frame;
    logic              window_free;
    logic              nak_allowed;
    logic              seq_is_exp;
    logic              accept_arrival;
    logic              head_arrived;
    logic              resend_ok;
    logic              release_ok;
  } sts_t;

  // b lies in [a, c) modulo the sequence space
  function automatic logic in_window(logic [SEQ_W-1:0] a, logic [SEQ_W-1:0] b,
                                     logic [SEQ_W-1:0] c);
    return ((a <= b) && (b < c)) || ((c < a) && (a <= b)) || ((b < c) && (c < a));
  endfunction

  function automatic logic [EMIT_KINDS-1:0] cmd_emit_vec(cmd_t c);
    return {c.send_new, c.send_timeout, c.send_ack, c.send_nak, c.ack_tmr,
            c.deliver, c.send_resend, c.release_slot, c.status};
  endfunction

endpackage

// File: design/srarq_ctrl.sv
// sequencer of the arq controller: walks one event through its command steps
module srarq_ctrl
  import srarq_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_EVENT   = 6'b000010,
    ST_DELIVER = 6'b000100,
    ST_RESEND  = 6'b001000,
    ST_RELEASE = 6'b010000,
    ST_STATUS  = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_EVENT;
        end
      end
      ST_EVENT: begin
        if (sts.emit_ok) begin
          state_next = ST_STATUS;
          unique case (sts.req)
            REQ_NET:     cmd.send_new = sts.window_free;
            REQ_PHYS:    cmd.phys_set = 1'b1;
            REQ_ACK_TO:  cmd.send_ack = 1'b1;
            REQ_DATA_TO: cmd.send_timeout = 1'b1;
            REQ_FRAME: begin
              if (sts.bad_frame) begin
                cmd.send_nak = sts.nak_allowed;
              end else begin
                unique case (sts.kind)
                  KIND_DATA: begin
                    if (!sts.seq_is_exp && sts.nak_allowed) begin
                      cmd.send_nak = 1'b1;
                    end else begin
                      cmd.ack_tmr = 1'b1;
                    end
                    cmd.mark   = sts.accept_arrival;
                    state_next = sts.accept_arrival ? ST_DELIVER : ST_RELEASE;
                  end
                  KIND_NAK:   state_next = ST_RESEND;
                  KIND_ACK,
                  KIND_OTHER: state_next = ST_RELEASE;
                  default:    state_next = ST_RELEASE;
                endcase
              end
            end
            default: ;
          endcase
        end
      end
      ST_DELIVER: begin
        if (sts.emit_ok) begin
          if (sts.head_arrived) begin
            cmd.deliver = 1'b1;
          end else begin
            state_next = ST_RELEASE;
          end
        end
      end
      ST_RESEND: begin
        if (sts.emit_ok) begin
          cmd.send_resend = sts.resend_ok;
          state_next      = ST_RELEASE;
        end
      end
      ST_RELEASE: begin
        if (sts.emit_ok) begin
          if (sts.release_ok) begin
            cmd.release_slot = 1'b1;
          end else begin
            state_next = ST_STATUS;
          end
        end
      end
      ST_STATUS: begin
        if (sts.emit_ok) begin
          cmd.status = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: design/srarq_dp.sv
// datapath of the arq controller: window pointers, arrival map, output register
module srarq_dp
  import srarq_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  in_t   in_item,
  input  cmd_t  cmd,
  output sts_t  sts,
  output logic  out_valid,
  input  logic  out_ready,
  output item_t out_item
);

  in_t               ev;
  logic [SEQ_W-1:0]  next_send_seq, next_send_seq_next;
  logic [SEQ_W-1:0]  expected_seq, expected_seq_next;
  logic [SEQ_W-1:0]  oldest_unacked, oldest_unacked_next;
  logic [SEQ_W-1:0]  window_upper, window_upper_next;
  logic [CNT_W-1:0]  outstanding_count, outstanding_count_next;
  logic              phys_ready_flag, phys_ready_flag_next;
  logic              nak_allowed, nak_allowed_next;
  logic [WINDOW-1:0] arrived_map, arrived_map_next;

  logic              emit;
  logic              any_send;
  logic              emit_ok;
  item_t             item;
  logic [SEQ_W-1:0]  ack_value;
  logic [SEQ_W-1:0]  resend_seq;
  logic [SEQ_W-1:0]  timer_seq;
  logic [SEQ_W-1:0]  timeout_seq;
  logic [LEN_W-1:0]  dlen;
  logic [LEN_W-1:0]  dlen_raw;

  assign emit     = |cmd_emit_vec(cmd);
  assign any_send = cmd.send_new | cmd.send_timeout | cmd.send_ack | cmd.send_nak |
                    cmd.send_resend;
  assign emit_ok  = !out_valid || out_ready;

  assign ack_value   = expected_seq - SEQ_W'(1);
  assign resend_seq  = ev.rx_ack + SEQ_W'(1);
  assign timer_seq   = SEQ_W'(ev.timer_slot);
  assign timeout_seq = in_window(oldest_unacked, timer_seq, next_send_seq) ?
                       timer_seq : timer_seq + SEQ_W'(WINDOW);

  assign dlen_raw = ev.frame_len - LEN_W'(HEADER_BYTES);
  always_comb begin
    if (ev.frame_len < LEN_W'(HEADER_BYTES)) begin
      dlen = '0;
    end else if (dlen_raw > LEN_W'(PACKET_BYTES)) begin
      dlen = LEN_W'(PACKET_BYTES);
    end else begin
      dlen = dlen_raw;
    end
  end

  always_comb begin
    sts.emit_ok        = emit_ok;
    sts.req            = ev.req_type;
    sts.kind           = ev.rx_kind;
    sts.bad_frame      = !ev.crc_ok || (ev.frame_len < LEN_W'(MIN_FRAME_LEN));
    sts.window_free    = outstanding_count < CNT_W'(WINDOW);
    sts.nak_allowed    = nak_allowed;
    sts.seq_is_exp     = ev.rx_seq == expected_seq;
    sts.accept_arrival = in_window(expected_seq, ev.rx_seq, window_upper) &&
                         !arrived_map[ev.rx_seq[SLOT_W-1:0]];
    sts.head_arrived   = arrived_map[expected_seq[SLOT_W-1:0]];
    sts.resend_ok      = in_window(oldest_unacked, resend_seq, next_send_seq);
    sts.release_ok     = in_window(oldest_unacked, ev.rx_ack, next_send_seq);
  end

  always_comb begin
    item = '0;
    priority if (cmd.send_new) begin
      item.action  = ACT_SEND;
      item.seq_out = next_send_seq;
      item.ack_out = ack_value;
      item.slot    = next_send_seq[SLOT_W-1:0];
    end else if (cmd.send_timeout) begin
      item.action  = ACT_SEND;
      item.seq_out = timeout_seq;
      item.ack_out = ack_value;
      item.slot    = timeout_seq[SLOT_W-1:0];
    end else if (cmd.send_resend) begin
      item.action  = ACT_SEND;
      item.seq_out = resend_seq;
      item.ack_out = ack_value;
      item.slot    = resend_seq[SLOT_W-1:0];
    end else if (cmd.send_ack) begin
      item.action  = ACT_ACK;
      item.ack_out = ack_value;
    end else if (cmd.send_nak) begin
      item.action  = ACT_NAK;
      item.ack_out = ack_value;
    end else if (cmd.ack_tmr) begin
      item.action = ACT_ACK_TIMER;
    end else if (cmd.deliver) begin
      item.action      = ACT_DELIVER;
      item.slot        = expected_seq[SLOT_W-1:0];
      item.deliver_len = dlen;
    end else if (cmd.release_slot) begin
      item.action = ACT_STOP;
      item.slot   = oldest_unacked[SLOT_W-1:0];
    end else begin
      item.action     = ACT_STATUS;
      item.net_enable = (outstanding_count < CNT_W'(WINDOW)) && phys_ready_flag;
      item.last       = 1'b1;
    end
  end

  always_comb begin
    next_send_seq_next     = next_send_seq;
    expected_seq_next      = expected_seq;
    oldest_unacked_next    = oldest_unacked;
    window_upper_next      = window_upper;
    outstanding_count_next = outstanding_count;
    phys_ready_flag_next   = phys_ready_flag;
    nak_allowed_next       = nak_allowed;
    arrived_map_next       = arrived_map;

    if (cmd.phys_set) begin
      phys_ready_flag_next = 1'b1;
    end
    if (any_send) begin
      phys_ready_flag_next = 1'b0;
    end
    if (cmd.send_new) begin
      outstanding_count_next = outstanding_count + CNT_W'(1);
      next_send_seq_next     = next_send_seq + SEQ_W'(1);
    end
    if (cmd.send_nak) begin
      nak_allowed_next = 1'b0;
    end
    if (cmd.mark) begin
      arrived_map_next[ev.rx_seq[SLOT_W-1:0]] = 1'b1;
    end
    if (cmd.deliver) begin
      arrived_map_next[expected_seq[SLOT_W-1:0]] = 1'b0;
      nak_allowed_next  = 1'b1;
      expected_seq_next = expected_seq + SEQ_W'(1);
      window_upper_next = window_upper + SEQ_W'(1);
    end
    if (cmd.release_slot) begin
      if (outstanding_count != '0) begin
        outstanding_count_next = outstanding_count - CNT_W'(1);
      end
      oldest_unacked_next = oldest_unacked + SEQ_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next_send_seq     <= '0;
      expected_seq      <= '0;
      oldest_unacked    <= '0;
      window_upper      <= SEQ_W'(WINDOW % SEQ_COUNT);
      outstanding_count <= '0;
      phys_ready_flag   <= 1'b0;
      nak_allowed       <= 1'b1;
      arrived_map       <= '0;
      out_valid         <= 1'b0;
    end else begin
      next_send_seq     <= next_send_seq_next;
      expected_seq      <= expected_seq_next;
      oldest_unacked    <= oldest_unacked_next;
      window_upper      <= window_upper_next;
      outstanding_count <= outstanding_count_next;
      phys_ready_flag   <= phys_ready_flag_next;
      nak_allowed       <= nak_allowed_next;
      arrived_map       <= arrived_map_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ev <= in_item;
    end
    if (emit) begin
      out_item <= item;
    end
  end

endmodule

// File: design/selective_repeat_arq_controller.sv
// top level of the selective repeat arq controller
//
//   channel  dir  tdata fields (low to high)                          tuser               tlast
//   s_*      in   frame_len crc_ok rx_seq rx_ack timer_slot           req_type rx_kind    -
//   m_*      out  seq_out ack_out slot deliver_len net_enable         action              last
//
// an event: accept, dispatch, for an accepted data frame a delivery per slot plus a check,
// for a nak a resend, for a good frame a release per acked slot plus a check, the status item.
// the sequencer emits at most one item per cycle into a single output register.
// rst is synchronous and clears counters, the arrival map and all pointers but window_upper.
// a stalled output register holds the sequencer; input is taken only between events.
module selective_repeat_arq_controller
  import srarq_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // frame_len, crc_ok, rx_seq, rx_ack, timer_slot
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  // req_type, rx_kind
  input  logic [IN_TUSER_W-1:0]  s_tuser,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // seq_out, ack_out, slot, deliver_len, net_enable
  output logic [OUT_TDATA_W-1:0] m_tdata,
  // action
  output logic [OUT_TUSER_W-1:0] m_tuser,
  output logic                   m_tlast
);

`include "assert_macros.svh"

  in_t   in_item;
  cmd_t  cmd;
  sts_t  sts;
  item_t out_item;
  logic  [EMIT_KINDS-1:0] emit_vec;
  logic  emit_any;

  assign in_item.req_type   = s_tuser[REQ_W-1:0];
  assign in_item.rx_kind    = s_tuser[REQ_W +: KIND_W];
  assign in_item.frame_len  = s_tdata[LEN_W-1:0];
  assign in_item.crc_ok     = s_tdata[LEN_W];
  assign in_item.rx_seq     = s_tdata[LEN_W+1 +: SEQ_W];
  assign in_item.rx_ack     = s_tdata[LEN_W+1+SEQ_W +: SEQ_W];
  assign in_item.timer_slot = s_tdata[LEN_W+1+2*SEQ_W +: SLOT_W];

  srarq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  srarq_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_item   (in_item),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_item  (out_item)
  );

  assign m_tuser = out_item.action;
  assign m_tlast = out_item.last;
  assign m_tdata = {out_item.net_enable, out_item.deliver_len, out_item.slot,
                    out_item.ack_out, out_item.seq_out};

  assign emit_vec = cmd_emit_vec(cmd);
  assign emit_any = |emit_vec;

  `ASSERT_ALWAYS(a_one_emit, clk, rst, $onehot0(emit_vec), "two items in one cycle")
  `ASSERT_ALWAYS(a_emit_room, clk, rst, !(emit_any && !sts.emit_ok), "item into full register")
  `ASSERT_NEXT(a_busy_after_accept, clk, rst, s_tvalid && s_tready, !s_tready, "input mid event")
  `ASSERT_ALWAYS(a_last_is_status, clk, rst, !m_tvalid || (m_tlast == (m_tuser == ACT_STATUS)), "last")

endmodule

// File: test/selective_repeat_arq_controller_tb.sv
// self-checking testbench of the selective repeat arq controller: directed table then random
module selective_repeat_arq_controller_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import srarq_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int RANDOM_ITEMS = 355;
  localparam int HOLD_CYCLES  = 300;
  localparam int TAIL_CYCLES  = 40;

  localparam logic [REQ_W-1:0] REQ_BOGUS_LO = 3'd5;
  localparam logic [REQ_W-1:0] REQ_BOGUS_HI = 3'd7;

  typedef struct packed {
    in_t        ev;
    logic [1:0] npin;
    item_t      r0;
    item_t      r1;
    item_t      r2;
  } row_t;

  localparam item_t NO_CMD  = '0;
  localparam item_t ST_OFF  = '{ACT_STATUS, 5'd0, 5'd0, 4'd0, 9'd0, 1'b0, 1'b1};
  localparam item_t ST_ON   = '{ACT_STATUS, 5'd0, 5'd0, 4'd0, 9'd0, 1'b1, 1'b1};
  localparam item_t ACK_M1  = '{ACT_ACK, 5'd0, SEQ_W'(SEQ_COUNT - 1), 4'd0, 9'd0, 1'b0, 1'b0};
  localparam item_t NAK_M1  = '{ACT_NAK, 5'd0, SEQ_W'(SEQ_COUNT - 1), 4'd0, 9'd0, 1'b0, 1'b0};
  localparam item_t TMR_CMD = '{ACT_ACK_TIMER, 5'd0, 5'd0, 4'd0, 9'd0, 1'b0, 1'b0};
  localparam item_t DLV_MAX = '{ACT_DELIVER, 5'd0, 5'd0, 4'd0, LEN_W'(PACKET_BYTES), 1'b0, 1'b0};

  // fields: req_type, frame_len, crc_ok, rx_kind, rx_seq, rx_ack, timer_slot
  localparam row_t PLAN [25] = '{
    '{'{REQ_BOGUS_HI, 9'd511, 1'b1, KIND_OTHER, 5'd31, 5'd31, 4'd15}, 2'd1, ST_OFF, NO_CMD, NO_CMD},
    '{'{REQ_PHYS, 9'd0, 1'b0, KIND_DATA, 5'd0, 5'd0, 4'd0}, 2'd1, ST_ON, NO_CMD, NO_CMD},
    '{'{REQ_ACK_TO, 9'd0, 1'b0, KIND_DATA, 5'd0, 5'd0, 4'd0}, 2'd2, ACK_M1, ST_OFF, NO_CMD},
    '{'{REQ_FRAME, 9'd0, 1'b0, KIND_DATA, 5'd0, 5'd0, 4'd0}, 2'd2, NAK_M1, ST_OFF, NO_CMD},
    '{'{REQ_FRAME, 9'd4, 1'b1, KIND_DATA, 5'd0, 5'd0, 4'd0}, 2'd1, ST_OFF, NO_CMD, NO_CMD},
    '{'{REQ_FRAME, 9'd263, 1'b1, KIND_DATA, 5'd0, 5'd0, 4'd0}, 2'd3, TMR_CMD, DLV_MAX, ST_OFF},
    '{'{REQ_FRAME, 9'd511, 1'b1, KIND_DATA, 5'd1, 5'd0, 4'd0}, 2'd0, NO_CMD, NO_CMD, NO_CMD},
    '{'{REQ_FRAME, 9'd7, 1'b1, KIND_DATA, 5'd5, 5'd0, 4'd0}, 2'd0, NO_CMD, NO_CMD, NO_CMD},
    '{'{REQ_FRAME, 9'd8, 1'b1, KIND_DATA, 5'd3, 5'd0, 4'd0}, 2'd0, NO_CMD, NO_CMD, NO_CMD},
    '{'{REQ_FRAME, 9'd6, 1'b1, KIND_DATA, 5'd2, 5'd0, 4'd0}, 2'd0, NO_CMD, NO_CMD, NO_CMD},
    '{'{REQ_FRAME, 9'd5, 1'b1, KIND_DATA, 5'd4, 5'd0, 4'd0}, 2'd0, NO_CMD, NO_CMD, NO_CMD},
    '{'{REQ_FRAME, 9'd40, 1'b1, KIND_DATA, 5'd4, 5'd0, 4'd0}, 2'd0, NO_CMD, NO_CMD, NO_CMD},
    '{'{REQ_FRAME, 9'd40, 1'b1, KIND_DATA, 5'd21, 5'd0, 4'd0}, 2'd0, NO_CMD, NO_CMD, NO_CMD},
    '{'{REQ_FRAME, 9'd40, 1'b1, KIND_DATA, 5'd22, 5'd0, 4'd0}, 2'd0, NO_CMD, NO_CMD, NO_CMD},
    '{'{REQ_NET, 9'd0, 1'b0, KIND_DATA, 5'd0, 5'd0, 4'd0}, 2'd0, NO_CMD, NO_CMD, NO_CMD},
    '{'{REQ_NET, 9'd0, 1'b0, KIND_DATA, 5'd0, 5'd0, 4'd0}, 2'd0, NO_CMD, NO_CMD, NO_CMD},
    '{'{REQ_NET, 9'd0, 1'b0, KIND_DATA, 5'd0, 5'd0, 4'd0}, 2'd0, NO_CMD, NO_CMD, NO_CMD},
    '{'{REQ_DATA_TO, 9'd0, 1'b0, KIND_DATA, 5'd0, 5'd0, 4'd1}, 2'd0, NO_CMD, NO_CMD, NO_CMD},
    '{'{REQ_DATA_TO, 9'd0, 1'b0, KIND_DATA, 5'd0, 5'd0, 4'd15}, 2'd0, NO_CMD, NO_CMD, NO_CMD},
    '{'{REQ_FRAME, 9'd20, 1'b1, KIND_NAK, 5'd0, 5'd0, 4'd0}, 2'd0, NO_CMD, NO_CMD, NO_CMD},
    '{'{REQ_FRAME, 9'd20, 1'b1, KIND_ACK, 5'd0, 5'd2, 4'd0}, 2'd0, NO_CMD, NO_CMD, NO_CMD},
    '{'{REQ_FRAME, 9'd20, 1'b1, KIND_OTHER, 5'd31, 5'd31, 4'd15}, 2'd0, NO_CMD, NO_CMD, NO_CMD},
    '{'{REQ_BOGUS_LO, 9'd0, 1'b0, KIND_DATA, 5'd0, 5'd0, 4'd0}, 2'd0, NO_CMD, NO_CMD, NO_CMD},
    '{'{REQ_PHYS, 9'd0, 1'b0, KIND_DATA, 5'd0, 5'd0, 4'd0}, 2'd0, NO_CMD, NO_CMD, NO_CMD},
    '{'{REQ_NET, 9'd0, 1'b0, KIND_DATA, 5'd0, 5'd0, 4'd0}, 2'd0, NO_CMD, NO_CMD, NO_CMD}
  };

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic [IN_TUSER_W-1:0]  s_tuser = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic [OUT_TUSER_W-1:0] m_tuser;
  logic                   m_tlast;

  // link state as the block should hold it
  logic [SEQ_W-1:0] snd_next;
  logic [SEQ_W-1:0] rcv_next;
  logic [SEQ_W-1:0] ack_base;
  logic [SEQ_W-1:0] upper_edge;
  int               in_flight;
  logic             phys_rdy;
  logic             nak_ok;
  logic             slot_full [WINDOW];

  item_t commands_due [$];
  int    faults = 0;
  bit    calm = 1'b0;
  int    holds_asked = 0;
  int    holds_taken = 0;

  selective_repeat_arq_controller dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // x in [lo, hi) modulo the sequence space
  function automatic bit seq_between(logic [SEQ_W-1:0] lo, logic [SEQ_W-1:0] x,
                                     logic [SEQ_W-1:0] hi);
    logic [SEQ_W-1:0] dx;
    logic [SEQ_W-1:0] dhi;
    dx  = x - lo;
    dhi = hi - lo;
    return dx < dhi;
  endfunction

  function automatic void push_cmd(logic [ACT_W-1:0] act, logic [SEQ_W-1:0] sq,
                                   logic [SEQ_W-1:0] ak, logic [SLOT_W-1:0] sl,
                                   logic [LEN_W-1:0] ln, logic en, logic lst);
    item_t c;
    c.action      = act;
    c.seq_out     = sq;
    c.ack_out     = ak;
    c.slot        = sl;
    c.deliver_len = ln;
    c.net_enable  = en;
    c.last        = lst;
    commands_due.push_back(c);
  endfunction

  function automatic void queue_send(logic [SEQ_W-1:0] sq);
    push_cmd(ACT_SEND, sq, rcv_next - 1'b1, sq[SLOT_W-1:0], '0, 1'b0, 1'b0);
    phys_rdy = 1'b0;
  endfunction

  function automatic void queue_ctrl(logic [ACT_W-1:0] act);
    push_cmd(act, '0, rcv_next - 1'b1, '0, '0, 1'b0, 1'b0);
    phys_rdy = 1'b0;
    if (act == ACT_NAK) nak_ok = 1'b0;
  endfunction

  function automatic void run_link_event(in_t ev);
    logic [SEQ_W-1:0] s;
    int dlen;
    unique case (ev.req_type)
      REQ_NET: begin
        if (in_flight < WINDOW) begin
          in_flight++;
          queue_send(snd_next);
          snd_next++;
        end
      end
      REQ_PHYS: phys_rdy = 1'b1;
      REQ_FRAME: begin
        if (!ev.crc_ok || ev.frame_len < MIN_FRAME_LEN) begin
          if (nak_ok) queue_ctrl(ACT_NAK);
        end else begin
          if (ev.rx_kind == KIND_DATA) begin
            if (ev.rx_seq != rcv_next && nak_ok) queue_ctrl(ACT_NAK);
            else push_cmd(ACT_ACK_TIMER, '0, '0, '0, '0, 1'b0, 1'b0);
            if (seq_between(rcv_next, ev.rx_seq, upper_edge) &&
                !slot_full[ev.rx_seq[SLOT_W-1:0]]) begin
              dlen = (ev.frame_len >= HEADER_BYTES) ? int'(ev.frame_len) - HEADER_BYTES : 0;
              if (dlen > PACKET_BYTES) dlen = PACKET_BYTES;
              slot_full[ev.rx_seq[SLOT_W-1:0]] = 1'b1;
              while (slot_full[rcv_next[SLOT_W-1:0]]) begin
                push_cmd(ACT_DELIVER, '0, '0, rcv_next[SLOT_W-1:0], LEN_W'(dlen), 1'b0, 1'b0);
                nak_ok = 1'b1;
                slot_full[rcv_next[SLOT_W-1:0]] = 1'b0;
                rcv_next++;
                upper_edge++;
              end
            end
          end
          if (ev.rx_kind == KIND_NAK) begin
            s = ev.rx_ack + 1'b1;
            if (seq_between(ack_base, s, snd_next)) queue_send(s);
          end
          while (seq_between(ack_base, ev.rx_ack, snd_next)) begin
            if (in_flight > 0) in_flight--;
            push_cmd(ACT_STOP, '0, '0, ack_base[SLOT_W-1:0], '0, 1'b0, 1'b0);
            ack_base++;
          end
        end
      end
      REQ_ACK_TO: queue_ctrl(ACT_ACK);
      REQ_DATA_TO: begin
        s = SEQ_W'(ev.timer_slot);
        if (!seq_between(ack_base, s, snd_next)) s = s + SEQ_W'(WINDOW);
        queue_send(s);
      end
      default: ;
    endcase
    push_cmd(ACT_STATUS, '0, '0, '0, '0, (in_flight < WINDOW) && phys_rdy, 1'b1);
  endfunction

  // mostly well-formed traffic around the current windows, some noise
  function automatic in_t pick_event(bit flood);
    in_t ev;
    int w;
    int k;
    logic [SEQ_W-1:0] span;
    ev   = in_t'($urandom);
    span = snd_next - ack_base;
    w    = $urandom_range(99);
    if (flood || w < 24) begin
      ev.req_type = REQ_NET;
    end else if (w < 38) begin
      ev.req_type = REQ_PHYS;
    end else if (w < 84) begin
      ev.req_type = REQ_FRAME;
      if ($urandom_range(9) != 0) ev.crc_ok = 1'b1;
      if ($urandom_range(3) != 0) ev.frame_len = LEN_W'($urandom_range(HEADER_BYTES, 263));
      k = $urandom_range(9);
      ev.rx_kind = (k < 5) ? KIND_DATA : (k < 7) ? KIND_ACK : (k < 9) ? KIND_NAK : KIND_OTHER;
      if ($urandom_range(9) < 7)
        ev.rx_seq = rcv_next +
                    SEQ_W'(($urandom_range(2) == 0) ? 0 : $urandom_range(0, WINDOW - 1));
      else if ($urandom_range(1) == 1)
        ev.rx_seq = rcv_next - SEQ_W'($urandom_range(1, 3));
      if (span != 0 && $urandom_range(9) < 7) begin
        ev.rx_ack = ack_base + SEQ_W'($urandom_range(0, span - 1));
        if (ev.rx_kind == KIND_NAK) ev.rx_ack = ev.rx_ack - 1'b1;
      end
    end else if (w < 90) begin
      ev.req_type = REQ_ACK_TO;
    end else if (w < 97) begin
      ev.req_type = REQ_DATA_TO;
    end else begin
      ev.req_type = REQ_W'($urandom_range(REQ_BOGUS_LO, REQ_BOGUS_HI));
    end
    return ev;
  endfunction

  task automatic offer(input row_t row);
    int n0;
    while (!calm && $urandom_range(99) < 37) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {row.ev.timer_slot, row.ev.rx_ack, row.ev.rx_seq, row.ev.crc_ok,
                 row.ev.frame_len};
    s_tuser  <= {row.ev.rx_kind, row.ev.req_type};
    do @(posedge clk); while (!s_tready);
    n0 = commands_due.size();
    run_link_event(row.ev);
    if (row.npin != 0) begin
      while (commands_due.size() > n0) void'(commands_due.pop_back());
      commands_due.push_back(row.r0);
      if (row.npin > 1) commands_due.push_back(row.r1);
      if (row.npin > 2) commands_due.push_back(row.r2);
    end
  endtask

  task automatic drain_link();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (commands_due.size() != 0);
  endtask

  // receive side: random stalls, calm stretch, one long hold-off
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (holds_taken != holds_asked) begin
        holds_taken++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (calm) begin
        m_tready <= 1'b1;
      end else begin
        m_tready <= ($urandom_range(99) >= 37);
      end
    end
  end

  always @(posedge clk) begin
    item_t got;
    item_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.action      = m_tuser;
      got.seq_out     = m_tdata[4:0];
      got.ack_out     = m_tdata[9:5];
      got.slot        = m_tdata[13:10];
      got.deliver_len = m_tdata[22:14];
      got.net_enable  = m_tdata[23];
      got.last        = m_tlast;
      if (commands_due.size() == 0) begin
        if (faults < 10)
          $display("%0t unexpected act %0d seq %0d ack %0d slot %0d len %0d en %0b last %0b",
                   $time, got.action, got.seq_out, got.ack_out, got.slot, got.deliver_len,
                   got.net_enable, got.last);
        faults++;
      end else begin
        want = commands_due.pop_front();
        if (got !== want) begin
          if (faults < 10) begin
            $display("%0t command mismatch", $time);
            $display("  want act %0d seq %0d ack %0d slot %0d len %0d en %0b last %0b",
                     want.action, want.seq_out, want.ack_out, want.slot, want.deliver_len,
                     want.net_enable, want.last);
            $display("  got  act %0d seq %0d ack %0d slot %0d len %0d en %0b last %0b",
                     got.action, got.seq_out, got.ack_out, got.slot, got.deliver_len,
                     got.net_enable, got.last);
          end
          faults++;
        end
      end
    end
  end

  initial begin
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin
    row_t r;
    int   n;
    int   useful;
    snd_next   = '0;
    rcv_next   = '0;
    ack_base   = '0;
    upper_edge = SEQ_W'(WINDOW);
    in_flight  = 0;
    phys_rdy   = 1'b0;
    nak_ok     = 1'b1;
    for (int i = 0; i < WINDOW; i++) slot_full[i] = 1'b0;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (PLAN[i]) offer(PLAN[i]);
    drain_link();

    useful = 0;
    for (n = 0; useful < RANDOM_ITEMS; n++) begin
      calm = (n >= 100 && n < 160);
      if (n == 200) holds_asked++;
      if (n == 300) drain_link();
      r    = '0;
      r.ev = pick_event(n >= 250 && n < 272);
      offer(r);
      if (r.ev.req_type <= REQ_DATA_TO) useful++;
    end

    drain_link();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (faults == 0 && commands_due.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
